[sv/spd_pkg.sv]
// Shared constants and types for the shortest path block.
package spd_pkg;
  localparam int unsigned MaxNodes = 256;
  localparam int unsigned MaxEdges = 4096;
  localparam int unsigned NodeW = $clog2(MaxNodes);
  localparam int unsigned EdgeW = $clog2(MaxEdges);
  localparam int unsigned DistW = 40;
  localparam int unsigned WtW = 32;
  localparam logic [DistW-1:0] DistOnes = {DistW{1'b1}};

  typedef enum logic [1:0] {
    CmdAdd   = 2'd0,
    CmdRun   = 2'd1,
    CmdClear = 2'd2,
    CmdNone  = 2'd3
  } cmd_e;

  // Request from the sequencer to the relaxation unit.
  typedef struct packed {
    logic [DistW-1:0] base;
    logic [WtW-1:0]   wt;
    logic [DistW-1:0] old;
    logic             reached;
  } relax_req_t;

  typedef struct packed {
    logic [DistW-1:0] sum;
    logic             take;
  } relax_rsp_t;
endpackage

[sv/spd_relax.sv]
// Shared add, saturate and compare unit used for every edge relaxation.
module spd_relax (
  input  spd_pkg::relax_req_t req_i,
  output spd_pkg::relax_rsp_t rsp_o
);
  import spd_pkg::*;
  logic [DistW:0] sum;
  always_comb begin
    sum = {1'b0, req_i.base} + {{(DistW+1-WtW){1'b0}}, req_i.wt};
    rsp_o.sum = sum[DistW] ? DistOnes : sum[DistW-1:0];
    rsp_o.take = !req_i.reached || (rsp_o.sum < req_i.old);
  end
endmodule

[sv/shortest_path_dijkstra.sv]
// Top level of the single-source shortest path engine.
// Usage: input transactions arrive on the s_axis group; tdata carries
// command, from node, to node and weight. An add-edge or a clear transaction
// completes in its accepting cycle, so such transactions may follow back to
// back, and neither produces an output.
// A run transaction first writes all 256 distance entries, then repeats
// rounds: a scan of the nodes in use for the nearest unsettled node, a step
// to settle it, a fetch and a destination check for every stored edge plus a
// relaxation for each edge that leaves the settled node towards a node in use,
// and a step to close the pass. Rounds end when no reached unsettled node is
// left. A source out of range ends the run right after the initialisation,
// and the result is then flagged unreachable.
// One result transaction (distance, unreachable flag, dropped-edge flag) is
// then offered on the m_axis group and held until the receiver takes it.
// s_axis_tready is low while a run is in progress or its result waits, and
// rises in the cycle after the result transaction.
// Reset clears the edge count, the overflow flag and sets node_count to 256.
// The edge store needs no clearing after reset; only written entries are read.
// The user must write configuration (node_count) only while idle; not enforced.
module shortest_path_dijkstra (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // command[1:0], from_node[9:2], to_node[17:10], weight[49:18], zero pad
  input  logic [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // distance[39:0], unreachable[40], edges_dropped[41], zero pad
  output logic [47:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [8:0]  cfg_wdata_i
);
  import spd_pkg::*;

  typedef enum logic [2:0] {
    StIdle, StInit, StScan, StEdgeRd, StEdge, StDistRd, StRelax, StDone
  } state_e;

  state_e state_q;
  logic [8:0] node_cnt_q, n_eff;
  logic [EdgeW:0] edge_total_q;
  logic overflow_q;

  // Memories.
  logic [2*NodeW+WtW-1:0] edge_mem [MaxEdges];
  logic [DistW-1:0] dist_mem [MaxNodes];
  logic [MaxNodes-1:0] settled_q, reached_q;

  logic [1:0]       cmd;
  logic [NodeW-1:0] a_in, b_in;
  logic [WtW-1:0]   w_in;
  assign cmd  = s_axis_tdata[1:0];
  assign a_in = s_axis_tdata[9:2];
  assign b_in = s_axis_tdata[17:10];
  assign w_in = s_axis_tdata[49:18];

  logic [NodeW-1:0] src_q, tgt_q, u_q, v_q;
  logic [8:0] idx_q;
  logic [EdgeW:0] k_q;
  logic found_q;
  logic [DistW-1:0] best_q, du_q, rd_q;
  logic [WtW-1:0] ew_q;
  logic [2*NodeW+WtW-1:0] erd_q;
  logic [DistW-1:0] res_dist_q, tgt_dist_q;
  logic res_unr_q, res_ovf_q, m_valid_q;
  logic [NodeW-1:0] rd_addr;

  relax_req_t req;
  relax_rsp_t rsp;
  assign req.base = du_q;
  assign req.wt = ew_q;
  assign req.old = rd_q;
  assign req.reached = reached_q[v_q];
  spd_relax u_relax (.req_i(req), .rsp_o(rsp));

  always_comb begin
    n_eff = (node_cnt_q == 9'd0) ? 9'd1 : node_cnt_q;
    if (n_eff > 9'(MaxNodes)) n_eff = 9'(MaxNodes);
  end

  assign s_axis_tready = (state_q == StIdle) && !m_valid_q;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata = {6'd0, res_ovf_q, res_unr_q, res_dist_q};

  logic [NodeW-1:0] idx_n;
  assign idx_n = idx_q[NodeW-1:0];

  // The scan reads the node under test; an edge check reads the destination
  // of the edge just fetched, so that its distance is ready for relaxation.
  always_comb begin
    case (state_q)
      StScan:   rd_addr = idx_n;
      StDistRd: rd_addr = erd_q[WtW +: NodeW];
      default:  rd_addr = v_q;
    endcase
  end

  // Memory ports: one write and one registered read for each, plus a
  // registered read of the target distance.
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid && cmd == CmdAdd && !edge_total_q[EdgeW])
      edge_mem[edge_total_q[EdgeW-1:0]] <= {a_in, b_in, w_in};
    erd_q <= edge_mem[k_q[EdgeW-1:0]];
    if (state_q == StInit) dist_mem[idx_n] <= (idx_n == src_q) ? '0 : DistOnes;
    else if (state_q == StRelax && rsp.take) dist_mem[v_q] <= rsp.sum;
    rd_q <= dist_mem[rd_addr];
    tgt_dist_q <= dist_mem[tgt_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      node_cnt_q <= 9'd256;
      edge_total_q <= '0;
      overflow_q <= 1'b0;
      m_valid_q <= 1'b0;
      settled_q <= '0;
      reached_q <= '0;
      idx_q <= '0;
      k_q <= '0;
      found_q <= 1'b0;
      src_q <= '0;
      tgt_q <= '0;
      u_q <= '0;
      v_q <= '0;
      best_q <= '0;
      du_q <= '0;
      ew_q <= '0;
      res_dist_q <= '0;
      res_unr_q <= 1'b0;
      res_ovf_q <= 1'b0;
    end else begin
      if (cfg_we_i) node_cnt_q <= cfg_wdata_i;
      if (m_valid_q && m_axis_tready) m_valid_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (s_axis_tready && s_axis_tvalid) begin
            case (cmd)
              CmdAdd: begin
                if (edge_total_q[EdgeW]) overflow_q <= 1'b1;
                else edge_total_q <= edge_total_q + 1'b1;
              end
              CmdClear: begin
                edge_total_q <= '0;
                overflow_q <= 1'b0;
              end
              CmdRun: begin
                src_q <= a_in;
                tgt_q <= b_in;
                idx_q <= '0;
                settled_q <= '0;
                reached_q <= '0;
                state_q <= StInit;
              end
              default: ;
            endcase
          end
        end
        StInit: begin
          // Every distance entry is written, the source entry with zero.
          if (idx_q == 9'(MaxNodes - 1)) begin
            idx_q <= '0;
            found_q <= 1'b0;
            if ({1'b0, src_q} < n_eff) begin
              reached_q[src_q] <= 1'b1;
              state_q <= StScan;
            end else state_q <= StDone;
          end else idx_q <= idx_q + 1'b1;
        end
        StScan: begin
          // Read of idx is issued this cycle; the compare uses the previous entry,
          // whose registered read is now in rd_q.
          if (idx_q != 9'd0) begin : cmp
            logic [NodeW-1:0] p;
            p = idx_n - 1'b1;
            if (reached_q[p] && !settled_q[p] && (!found_q || rd_q < best_q)) begin
              found_q <= 1'b1;
              best_q <= rd_q;
              u_q <= p;
            end
          end
          if (idx_q == n_eff) begin
            idx_q <= '0;
            state_q <= StEdgeRd;
          end else idx_q <= idx_q + 1'b1;
        end
        StEdgeRd: begin
          if (!found_q) state_q <= StDone;
          else begin
            settled_q[u_q] <= 1'b1;
            du_q <= best_q;
            k_q <= '0;
            state_q <= StEdge;
          end
        end
        StEdge: begin
          // Edge k is registered into erd_q during this state, so StDistRd sees it.
          if (k_q == edge_total_q) begin
            found_q <= 1'b0;
            state_q <= StScan;
          end else state_q <= StDistRd;
        end
        StDistRd: begin
          v_q <= erd_q[WtW +: NodeW];
          ew_q <= erd_q[WtW-1:0];
          if (erd_q[WtW+NodeW +: NodeW] == u_q &&
              {1'b0, erd_q[WtW +: NodeW]} < n_eff)
            state_q <= StRelax;
          else begin
            k_q <= k_q + 1'b1;
            state_q <= StEdge;
          end
        end
        StRelax: begin
          // rd_q now holds the distance of v_q.
          if (rsp.take) reached_q[v_q] <= 1'b1;
          k_q <= k_q + 1'b1;
          state_q <= StEdge;
        end
        StDone: begin
          idx_q <= '0;
          k_q <= '0;
          v_q <= tgt_q;
          state_q <= StIdle;
          m_valid_q <= 1'b1;
          res_ovf_q <= overflow_q;
          // The target distance was read in the previous cycle; no write
          // has happened since the last relaxation.
          if ({1'b0, tgt_q} < n_eff && reached_q[tgt_q]) begin
            res_unr_q <= 1'b0;
            res_dist_q <= tgt_dist_q;
          end else begin
            res_unr_q <= 1'b1;
            res_dist_q <= DistOnes;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  property p_busy_not_ready;
    @(posedge clk_i) disable iff (!rst_ni) (state_q != StIdle) |-> !s_axis_tready;
  endproperty
  a_busy: assert property (p_busy_not_ready) else $error("ready while busy");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("result lost");

  a_edge_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    edge_total_q <= (EdgeW+1)'(MaxEdges)) else $error("edge count overrun");
endmodule
